@@ src/bsa_pkg.sv @@
// Shared widths, register map and controller/datapath interface types.
package bsa_pkg;

   localparam int SEQ_W      = 64;
   localparam int LEN_W      = 7;
   localparam int CNT_W      = 7;
   localparam int MAG_W      = 6;
   localparam int ENERGY_W   = 17;
   localparam int PEAK_W     = 6;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic [LEN_W-1:0]      LEN_RESET      = 7'd64;
   localparam logic [CSR_ADDR_W-1:0] CSR_SEQ_LENGTH = 2'd0;

   typedef struct packed {
      logic load;     // take a new item, clear accumulators
      logic issue;    // evaluate the current lag and advance
      logic publish;  // move the totals into the output register
   } bsa_cmd_type;

   typedef struct packed {
      logic more;     // at least one lag is left to issue
      logic busy;     // lag pipeline still holds work
      logic out_free; // output register can take a result
   } bsa_sts_type;

endpackage

@@ src/binary_sequence_autocorrelation_top.sv @@
// Top level of the binary sequence autocorrelation block: register port, controller, datapath.
// Sequence: once an item is accepted, the controller issues its L-1 lags, with
//   L = min(seq_length, MAX_LENGTH), drains the lag pipeline, then publishes when the output register is free.
// A new item is taken only while the block is idle, so it waits until the last result has
//   been published; the lag walker evaluates one lag per cycle.
// Reset (synchronous, active high) idles the controller, empties the lag pipeline and
//   the output register, and sets seq_length to 64.
module binary_sequence_autocorrelation_top #(
   parameter int MAX_LENGTH = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   // input items
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [bsa_pkg::SEQ_W-1:0]         req_seq_bits,
   // result items
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [bsa_pkg::ENERGY_W-1:0]      rsp_energy,
   output logic [bsa_pkg::PEAK_W-1:0]        rsp_peak_sidelobe,
   // register port
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [bsa_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [bsa_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [bsa_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);
   import bsa_pkg::*;

   logic [LEN_W-1:0] seq_length_ff;
   logic [LEN_W-1:0] seq_length_in;
   logic             csr_write;
   bsa_cmd_type      cmd;
   bsa_sts_type      sts;

   // Register port: zero wait states, write lands in the access phase.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // Only the length register is decoded; writes elsewhere drop.
   always_comb begin
      seq_length_in = seq_length_ff;
      if (csr_write && (csr_paddr == CSR_SEQ_LENGTH)) begin
         seq_length_in = csr_pwdata[LEN_W-1:0];
      end
   end

   assign csr_prdata = (csr_paddr == CSR_SEQ_LENGTH) ? CSR_DATA_W'(seq_length_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_length_ff <= LEN_RESET;
      end else begin
         seq_length_ff <= seq_length_in;
      end
   end

   // Controller: takes an item only when the datapath is between items.
   bsa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Datapath: lag walker, three-stage lag pipeline, totals and output register.
   bsa_datapath #(
      .MAX_LENGTH (MAX_LENGTH)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .seq_length        (seq_length_ff),
      .req_seq_bits      (req_seq_bits),
      .cmd               (cmd),
      .sts               (sts),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_energy        (rsp_energy),
      .rsp_peak_sidelobe (rsp_peak_sidelobe)
   );

endmodule

@@ src/bsa_ctrl.sv @@
// Sequencer for one item: load, issue lags, drain the pipeline, publish.
module bsa_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  bsa_pkg::bsa_sts_type sts,
   output bsa_pkg::bsa_cmd_type cmd
);
   import bsa_pkg::*;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_RUN    = 2'd1;
   localparam logic [1:0] ST_DRAIN  = 2'd2;
   localparam logic [1:0] ST_FINISH = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (sts.more) begin
               cmd.issue = 1'b1;
            end else begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!sts.busy) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (sts.out_free) begin
               cmd.publish = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign req_stall = (state_ff != ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ src/bsa_datapath.sv @@
// Lag datapath: shifted xor, popcount, magnitude and square, accumulation, output register.
module bsa_datapath #(
   parameter int MAX_LENGTH = 64
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [bsa_pkg::LEN_W-1:0]       seq_length,
   input  logic [bsa_pkg::SEQ_W-1:0]       req_seq_bits,
   input  bsa_pkg::bsa_cmd_type            cmd,
   output bsa_pkg::bsa_sts_type            sts,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [bsa_pkg::ENERGY_W-1:0]    rsp_energy,
   output logic [bsa_pkg::PEAK_W-1:0]      rsp_peak_sidelobe
);
   import bsa_pkg::*;

   localparam logic [LEN_W-1:0] MAX_LEN_C = LEN_W'(MAX_LENGTH);

   function automatic logic [CNT_W-1:0] count_ones(input logic [SEQ_W-1:0] v);
      logic [3:0]       part [SEQ_W/8];
      logic [CNT_W-1:0] total;
      total = '0;
      for (int b = 0; b < SEQ_W/8; b++) begin
         part[b] = '0;
         for (int j = 0; j < 8; j++) begin
            part[b] = part[b] + 4'(v[8*b+j]);
         end
      end
      for (int b = 0; b < SEQ_W/8; b++) begin
         total = total + CNT_W'(part[b]);
      end
      return total;
   endfunction

   logic [LEN_W-1:0]      len_eff;
   logic [MAX_LENGTH-1:0] len_mask;
   logic [MAX_LENGTH-1:0] seq_masked;

   logic [MAX_LENGTH-1:0] seq_ff,  seq_in;
   logic [MAX_LENGTH-1:0] sh_ff,   sh_in;
   logic [MAX_LENGTH-1:0] mask_ff, mask_in;
   logic [LEN_W-1:0]      span_ff, span_in;

   logic [MAX_LENGTH-1:0] diff;
   logic                  p1_v_ff,     p1_v_in;
   logic [CNT_W-1:0]      p1_mism_ff,  p1_mism_in;
   logic [LEN_W-1:0]      p1_span_ff,  p1_span_in;

   logic [CNT_W:0]        twice;
   logic [CNT_W:0]        span_x;
   logic [CNT_W:0]        mag_full;
   logic                  p2_v_ff,     p2_v_in;
   logic [MAG_W-1:0]      p2_mag_ff,   p2_mag_in;

   logic [2*MAG_W-1:0]    sq;
   logic [ENERGY_W-1:0]   energy_acc_ff, energy_acc_in;
   logic [PEAK_W-1:0]     peak_acc_ff,   peak_acc_in;

   logic                  rsp_valid_ff,  rsp_valid_in;
   logic [ENERGY_W-1:0]   rsp_energy_ff, rsp_energy_in;
   logic [PEAK_W-1:0]     rsp_peak_ff,   rsp_peak_in;

   // Saturate the length and clear the unused elements.
   always_comb begin
      len_eff = (seq_length > MAX_LEN_C) ? MAX_LEN_C : seq_length;
      for (int i = 0; i < MAX_LENGTH; i++) begin
         len_mask[i] = (LEN_W'(i) < len_eff);
      end
      seq_masked = req_seq_bits[MAX_LENGTH-1:0] & len_mask;
   end

   // Lag walker: the shifted copy and the window mask both move right one per lag.
   always_comb begin
      seq_in  = seq_ff;
      sh_in   = sh_ff;
      mask_in = mask_ff;
      span_in = span_ff;
      if (cmd.load) begin
         seq_in  = seq_masked;
         sh_in   = seq_masked >> 1;
         mask_in = len_mask >> 1;
         span_in = (len_eff == '0) ? '0 : len_eff - LEN_W'(1);
      end else if (cmd.issue) begin
         sh_in   = sh_ff >> 1;
         mask_in = mask_ff >> 1;
         span_in = span_ff - LEN_W'(1);
      end
   end

   // Stage 1: count mismatches for this lag.
   always_comb begin
      diff       = (seq_ff ^ sh_ff) & mask_ff;
      p1_v_in    = cmd.issue;
      p1_mism_in = count_ones(SEQ_W'(diff));
      p1_span_in = span_ff;
   end

   // Stage 2: |C(k)| = |span - 2*mismatches|.
   always_comb begin
      twice     = {p1_mism_ff, 1'b0};
      span_x    = (CNT_W+1)'(p1_span_ff);
      mag_full  = (span_x >= twice) ? (span_x - twice) : (twice - span_x);
      p2_v_in   = p1_v_ff;
      p2_mag_in = mag_full[MAG_W-1:0];
   end

   // Stage 3: square and accumulate, track the peak.
   always_comb begin
      sq            = (2*MAG_W)'(p2_mag_ff) * (2*MAG_W)'(p2_mag_ff);
      energy_acc_in = energy_acc_ff;
      peak_acc_in   = peak_acc_ff;
      if (cmd.load) begin
         energy_acc_in = '0;
         peak_acc_in   = '0;
      end else if (p2_v_ff) begin
         energy_acc_in = energy_acc_ff + ENERGY_W'(sq);
         if (PEAK_W'(p2_mag_ff) > peak_acc_ff) begin
            peak_acc_in = PEAK_W'(p2_mag_ff);
         end
      end
   end

   // Output register: hold while stalled.
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_energy_in = rsp_energy_ff;
      rsp_peak_in   = rsp_peak_ff;
      if (cmd.publish) begin
         rsp_valid_in  = 1'b1;
         rsp_energy_in = energy_acc_ff;
         rsp_peak_in   = peak_acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_v_ff      <= 1'b0;
         p2_v_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         p1_v_ff      <= p1_v_in;
         p2_v_ff      <= p2_v_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      seq_ff        <= seq_in;
      sh_ff         <= sh_in;
      mask_ff       <= mask_in;
      span_ff       <= span_in;
      p1_mism_ff    <= p1_mism_in;
      p1_span_ff    <= p1_span_in;
      p2_mag_ff     <= p2_mag_in;
      energy_acc_ff <= energy_acc_in;
      peak_acc_ff   <= peak_acc_in;
      rsp_energy_ff <= rsp_energy_in;
      rsp_peak_ff   <= rsp_peak_in;
   end

   assign sts.more     = (span_ff != '0);
   assign sts.busy     = p1_v_ff || p2_v_ff;
   assign sts.out_free = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_energy        = rsp_energy_ff;
   assign rsp_peak_sidelobe = rsp_peak_ff;

endmodule

@@ src/bsa_check.sv @@
// Port-level checks for the autocorrelation block and their binding to the top level.
module bsa_check (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [bsa_pkg::ENERGY_W-1:0]  rsp_energy,
   input logic [bsa_pkg::PEAK_W-1:0]    rsp_peak_sidelobe
);
   import bsa_pkg::*;

   // An accepted item keeps the block busy in the next cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input not stalled after an accepted item");

   // A new result comes only out of an item in progress.
   a_result_from_item: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result raised while no item was in progress");

   // Hold a stalled result.
   a_result_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
         (rsp_valid && $stable(rsp_energy) && $stable(rsp_peak_sidelobe)))
      else $error("stalled result changed");

   // The energy includes the square of the peak sidelobe.
   a_energy_covers_peak: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         (rsp_energy >= (ENERGY_W'(rsp_peak_sidelobe) * ENERGY_W'(rsp_peak_sidelobe))))
      else $error("energy below peak sidelobe squared");

endmodule

bind binary_sequence_autocorrelation_top bsa_check u_bsa_check (.*);
